// ===== design/dns_answer_a_record_extractor_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the DNS answer A-record extractor
// Concurrent assertion wrappers; defining ASSERT_OFF compiles them away.
// ----------------------------------------------------------------------------
`ifndef DNS_ANSWER_A_RECORD_EXTRACTOR_CORE_ASSERT_SVH
`define DNS_ANSWER_A_RECORD_EXTRACTOR_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
// Antecedent implies consequent in the same cycle.
`define DNSAEX_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");
// Antecedent implies consequent in the following cycle.
`define DNSAEX_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define DNSAEX_ASSERT_SAME(label, clk, rstn, ante, cons)
`define DNSAEX_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

// ===== design/dnsaex_pkg.sv =====
// ----------------------------------------------------------------------------
// dnsaex_pkg
// Types and constants shared by the DNS answer A-record extractor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dnsaex_pkg;

    // Default receive buffer size in bytes.
    localparam int MAX_DATAGRAM_BYTES_DEF = 512;

    // Result queue sizing.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // Parser phases.
    typedef enum logic [3:0] {
        PH_HEADER   = 4'd0,
        PH_QUESTION = 4'd1,
        PH_NAME     = 4'd2,
        PH_TYPE     = 4'd3,
        PH_CLASS    = 4'd4,
        PH_TTL      = 4'd5,
        PH_LEN      = 4'd6,
        PH_DATA     = 4'd7,
        PH_DONE     = 4'd8
    } phase_t;

    // Result kinds.
    typedef enum logic [1:0] {
        KIND_ADDRESS   = 2'd0,
        KIND_END_OK    = 2'd1,
        KIND_END_TRUNC = 2'd2
    } result_kind_t;

    // Record type of an IPv4 address record.
    localparam logic [15:0] RR_TYPE_A = 16'd1;

    // Header byte positions.
    localparam int HDR_ANCOUNT_HI = 6;
    localparam int HDR_ANCOUNT_LO = 7;
    localparam int HDR_LAST_BYTE  = 11;

    // Input item.
    typedef struct packed {
        logic [7:0] rx_byte;
        logic       end_of_datagram;
    } in_item_t;

    // Result item.
    typedef struct packed {
        result_kind_t result_kind;
        logic [31:0]  ipv4_address;
        logic [15:0]  answer_number;
        logic [15:0]  answers_declared;
        logic         last_of_run;
    } result_t;

endpackage

// ===== design/dns_answer_a_record_extractor_core.sv =====
// ----------------------------------------------------------------------------
// dns_answer_a_record_extractor_core
// Parses a DNS response one byte per item and reports each IPv4 address
// record, followed by an end item marked complete or truncated.
// ----------------------------------------------------------------------------
// Channel   Direction  Ports                        Content
// s_        in         s_valid s_ready s_data       one datagram byte, end mark
// m_        out        m_valid m_ready m_data       address or end item
// cfg_      in         cfg_valid cfg_ready cfg_data question name length
//
// Each accepted byte is parsed in the cycle it is taken; one byte per cycle while s_ready is high.
// A byte causes at most two results, which enter a four-entry result queue;
// the queue drains one item per cycle while m_ready is high, so the sustained
// rate is one byte per cycle except where bytes give two results in a row.
// s_ready is low while fewer than two queue entries are free.
// Reset clears the parser and sets the question name length to 1.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dns_answer_a_record_extractor_core #(
    parameter int MAX_DATAGRAM_BYTES = dnsaex_pkg::MAX_DATAGRAM_BYTES_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  dnsaex_pkg::in_item_t s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output dnsaex_pkg::result_t  m_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [7:0]           cfg_data
);

    `include "dns_answer_a_record_extractor_core_assert.svh"

    localparam int POS_W = $clog2(MAX_DATAGRAM_BYTES + 1);
    localparam int PTR_W = dnsaex_pkg::FIFO_PTR_W;
    localparam int CNT_W = dnsaex_pkg::FIFO_CNT_W;

    // Parser state.
    logic [7:0]         qnb_reg;
    dnsaex_pkg::phase_t phase_reg, phase_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [15:0]        cnt_reg, cnt_next;
    logic [15:0]        decl_reg, decl_next;
    logic [15:0]        seen_reg, seen_next;
    logic [15:0]        type_reg, type_next;
    logic [15:0]        len_reg, len_next;
    logic [31:0]        addr_reg, addr_next;

    // Results of the current item.
    dnsaex_pkg::result_t res0, res1;
    logic [1:0]          n_results;

    // Result queue.
    dnsaex_pkg::result_t fifo_reg [dnsaex_pkg::FIFO_DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]    count_reg;

    logic        in_accept;
    logic        out_pop;
    logic [7:0]  b;
    logic [15:0] cnt_inc;
    logic [15:0] seen_inc;
    logic        addr_emit;
    logic [15:0] question_len;

    assign b         = s_data.rx_byte;
    assign in_accept = s_valid && s_ready;
    assign out_pop   = m_valid && m_ready;
    assign cfg_ready = 1'b1;
    assign s_ready   = (count_reg <= CNT_W'(dnsaex_pkg::FIFO_DEPTH - 2));
    assign m_valid   = (count_reg != '0);
    assign m_data    = fifo_reg[rd_ptr_reg];

    assign cnt_inc      = cnt_reg + 16'd1;
    assign seen_inc     = seen_reg + 16'd1;
    assign question_len = {8'd0, qnb_reg} + 16'd4;

    // Byte parser: next state and the results caused by this byte.
    always_comb begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        cnt_next   = cnt_reg;
        decl_next  = decl_reg;
        seen_next  = seen_reg;
        type_next  = type_reg;
        len_next   = len_reg;
        addr_next  = addr_reg;
        addr_emit  = 1'b0;

        if (pos_reg < POS_W'(MAX_DATAGRAM_BYTES)) begin
            pos_next = pos_reg + POS_W'(1);
            case (phase_reg)
                dnsaex_pkg::PH_HEADER: begin
                    if (pos_reg == POS_W'(dnsaex_pkg::HDR_ANCOUNT_HI)) begin
                        decl_next = {b, 8'd0};
                    end
                    if (pos_reg == POS_W'(dnsaex_pkg::HDR_ANCOUNT_LO)) begin
                        decl_next = decl_reg | {8'd0, b};
                    end
                    if (pos_reg >= POS_W'(dnsaex_pkg::HDR_LAST_BYTE)) begin
                        phase_next = dnsaex_pkg::PH_QUESTION;
                        cnt_next   = '0;
                    end
                end
                dnsaex_pkg::PH_QUESTION: begin
                    cnt_next = cnt_inc;
                    if (cnt_inc >= question_len) begin
                        cnt_next   = '0;
                        phase_next = (seen_reg >= decl_reg) ? dnsaex_pkg::PH_DONE
                                                            : dnsaex_pkg::PH_NAME;
                    end
                end
                dnsaex_pkg::PH_NAME: begin
                    cnt_next = cnt_inc;
                    if (cnt_inc >= 16'd2) begin
                        phase_next = dnsaex_pkg::PH_TYPE;
                        cnt_next   = '0;
                        type_next  = '0;
                    end
                end
                dnsaex_pkg::PH_TYPE: begin
                    type_next = {type_reg[7:0], b};
                    cnt_next  = cnt_inc;
                    if (cnt_inc >= 16'd2) begin
                        phase_next = dnsaex_pkg::PH_CLASS;
                        cnt_next   = '0;
                    end
                end
                dnsaex_pkg::PH_CLASS: begin
                    cnt_next = cnt_inc;
                    if (cnt_inc >= 16'd2) begin
                        phase_next = dnsaex_pkg::PH_TTL;
                        cnt_next   = '0;
                    end
                end
                dnsaex_pkg::PH_TTL: begin
                    cnt_next = cnt_inc;
                    if (cnt_inc >= 16'd4) begin
                        phase_next = dnsaex_pkg::PH_LEN;
                        cnt_next   = '0;
                        len_next   = '0;
                    end
                end
                dnsaex_pkg::PH_LEN: begin
                    len_next = {len_reg[7:0], b};
                    cnt_next = cnt_inc;
                    if (cnt_inc >= 16'd2) begin
                        cnt_next = '0;
                        if ({len_reg[7:0], b} == 16'd0) begin
                            // Empty data: the answer ends here.
                            seen_next  = seen_inc;
                            phase_next = (seen_inc >= decl_reg) ? dnsaex_pkg::PH_DONE
                                                                : dnsaex_pkg::PH_NAME;
                        end else begin
                            phase_next = dnsaex_pkg::PH_DATA;
                            addr_next  = '0;
                        end
                    end
                end
                dnsaex_pkg::PH_DATA: begin
                    if (cnt_reg < 16'd4) begin
                        addr_next = {addr_reg[23:0], b};
                    end
                    cnt_next = cnt_inc;
                    if (cnt_inc == 16'd4 && type_reg == dnsaex_pkg::RR_TYPE_A &&
                        len_reg >= 16'd4) begin
                        addr_emit = 1'b1;
                    end
                    if (cnt_inc >= len_reg) begin
                        cnt_next   = '0;
                        seen_next  = seen_inc;
                        phase_next = (seen_inc >= decl_reg) ? dnsaex_pkg::PH_DONE
                                                            : dnsaex_pkg::PH_NAME;
                    end
                end
                dnsaex_pkg::PH_DONE: begin
                    // Bytes past the answers are ignored.
                end
                default: begin
                end
            endcase
        end

        // Address result, if any, comes first.
        res0.result_kind      = dnsaex_pkg::KIND_ADDRESS;
        res0.ipv4_address     = addr_next;
        res0.answer_number    = seen_reg;
        res0.answers_declared = decl_next;
        res0.last_of_run      = !s_data.end_of_datagram;

        // End result reflects the state after this byte.
        res1.result_kind      = (phase_next == dnsaex_pkg::PH_DONE) ?
                                dnsaex_pkg::KIND_END_OK : dnsaex_pkg::KIND_END_TRUNC;
        res1.ipv4_address     = '0;
        res1.answer_number    = '0;
        res1.answers_declared = decl_next;
        res1.last_of_run      = 1'b1;

        if (addr_emit && s_data.end_of_datagram) begin
            n_results = 2'd2;
        end else if (addr_emit) begin
            n_results = 2'd1;
        end else if (s_data.end_of_datagram) begin
            n_results = 2'd1;
            res0      = res1;
        end else begin
            n_results = 2'd0;
        end

        // The end mark returns the parser to its reset state.
        if (s_data.end_of_datagram) begin
            phase_next = dnsaex_pkg::PH_HEADER;
            pos_next   = '0;
            cnt_next   = '0;
            decl_next  = '0;
            seen_next  = '0;
            type_next  = '0;
            len_next   = '0;
            addr_next  = '0;
        end
    end

    // Configuration register and parser state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            qnb_reg   <= 8'd1;
            phase_reg <= dnsaex_pkg::PH_HEADER;
            pos_reg   <= '0;
            cnt_reg   <= '0;
            decl_reg  <= '0;
            seen_reg  <= '0;
            type_reg  <= '0;
            len_reg   <= '0;
            addr_reg  <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                qnb_reg <= cfg_data;
            end
            if (in_accept) begin
                phase_reg <= phase_next;
                pos_reg   <= pos_next;
                cnt_reg   <= cnt_next;
                decl_reg  <= decl_next;
                seen_reg  <= seen_next;
                type_reg  <= type_next;
                len_reg   <= len_next;
                addr_reg  <= addr_next;
            end
        end
    end

    // Result queue pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (in_accept) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(n_results);
            end
            if (out_pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_reg + (in_accept ? CNT_W'(n_results) : CNT_W'(0))
                       - (out_pop ? CNT_W'(1) : CNT_W'(0));
        end
    end

    // Result queue storage.
    always_ff @(posedge aclk) begin
        if (in_accept && n_results != 2'd0) begin
            fifo_reg[wr_ptr_reg] <= res0;
        end
        if (in_accept && n_results == 2'd2) begin
            fifo_reg[wr_ptr_reg + PTR_W'(1)] <= res1;
        end
    end

    // Checks on the parser and the queue.
    `DNSAEX_ASSERT_SAME(a_fifo_bound, aclk, aresetn, 1'b1, count_reg <= CNT_W'(dnsaex_pkg::FIFO_DEPTH))
    `DNSAEX_ASSERT_SAME(a_pos_bound, aclk, aresetn, 1'b1, pos_reg <= POS_W'(MAX_DATAGRAM_BYTES))
    `DNSAEX_ASSERT_SAME(a_header_done, aclk, aresetn, phase_reg != dnsaex_pkg::PH_HEADER, pos_reg >= POS_W'(12))
    `DNSAEX_ASSERT_NEXT(a_eod_clears, aclk, aresetn, in_accept && s_data.end_of_datagram, pos_reg == '0 && phase_reg == dnsaex_pkg::PH_HEADER)
    `DNSAEX_ASSERT_NEXT(a_eod_queued, aclk, aresetn, in_accept && s_data.end_of_datagram, m_valid)

endmodule
